// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL file that carries checks (base64url_decoder.sv).
// Each macro expects signals named clk and rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/b64u_pkg.sv =====
// Types, character constants and helper functions for the base64url decoder.
// No dependencies; imported by every module of the block.
package b64u_pkg;

    localparam int RESULTS_MAX = 4;
    localparam int COUNT_W     = 3;

    localparam logic [7:0] CHAR_PAD    = 8'h3d;  // '='
    localparam logic [7:0] CHAR_DASH   = 8'h2d;  // '-'
    localparam logic [7:0] CHAR_USCORE = 8'h5f;  // '_'
    localparam logic [7:0] CHAR_UP_A   = 8'h41;
    localparam logic [7:0] CHAR_UP_Z   = 8'h5a;
    localparam logic [7:0] CHAR_LO_A   = 8'h61;
    localparam logic [7:0] CHAR_LO_Z   = 8'h7a;
    localparam logic [7:0] CHAR_DIG_0  = 8'h30;
    localparam logic [7:0] CHAR_DIG_9  = 8'h39;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_string;
    } b64u_in_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       is_status;
        logic       status_code;
        logic       last_result;
    } b64u_result_t;

    // Results caused by one character, oldest in slot 0.
    typedef struct packed {
        logic [COUNT_W-1:0]                 count;
        b64u_result_t [RESULTS_MAX-1:0]     slots;
    } b64u_group_t;

    typedef struct packed {
        logic               free;   // buffer can take a new group this cycle
        logic [COUNT_W-1:0] count;
    } b64u_buf_status_t;

    // {valid, sextet}
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = '0;
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z)
            r = {1'b1, 6'(c - CHAR_UP_A)};
        else if (c >= CHAR_LO_A && c <= CHAR_LO_Z)
            r = {1'b1, 6'(c - CHAR_LO_A + 8'd26)};
        else if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9)
            r = {1'b1, 6'(c - CHAR_DIG_0 + 8'd52)};
        else if (c == CHAR_DASH)
            r = {1'b1, 6'd62};
        else if (c == CHAR_USCORE)
            r = {1'b1, 6'd63};
        return r;
    endfunction

    function automatic b64u_result_t make_data(input logic [7:0] b);
        b64u_result_t r;
        r.byte_out    = b;
        r.is_status   = 1'b0;
        r.status_code = 1'b0;
        r.last_result = 1'b0;
        return r;
    endfunction

    function automatic b64u_result_t make_status(input logic bad);
        b64u_result_t r;
        r.byte_out    = 8'h00;
        r.is_status   = 1'b1;
        r.status_code = bad;
        r.last_result = 1'b1;
        return r;
    endfunction

endpackage

// ===== src/b64u_decode.sv =====
// Decode state and per-character step: sextet lookup, group packing,
// trailing-character check. Depends on b64u_pkg.
module b64u_decode (
    input  logic                 clk,
    input  logic                 rst_n,
    input  b64u_pkg::b64u_in_t   item,
    input  logic                 advance,
    output b64u_pkg::b64u_group_t group
);
    import b64u_pkg::*;

    logic [1:0]  pos_reg,  pos_next;
    logic [17:0] hold_reg, hold_next;
    logic        stop_reg, stop_next;
    logic [1:0]  tc_reg,   tc_next;
    logic        tnp_reg,  tnp_next;

    logic [6:0]  sx;
    logic        take;
    logic        bad;
    logic [23:0] word;
    logic [COUNT_W-1:0] k;
    b64u_result_t [RESULTS_MAX-1:0] slots;

    always_comb
    begin
        sx        = sextet_of(item.char_in);
        take      = !stop_reg && (item.char_in != CHAR_PAD) && sx[6];
        word      = {hold_reg, sx[5:0]};
        pos_next  = pos_reg;
        hold_next = hold_reg;
        stop_next = stop_reg;
        tc_next   = tc_reg;
        tnp_next  = tnp_reg;
        k         = '0;
        slots     = '0;

        if (take)
        begin
            if (pos_reg == 2'd3)
            begin
                slots[0]  = make_data(word[23:16]);
                slots[1]  = make_data(word[15:8]);
                slots[2]  = make_data(word[7:0]);
                k         = COUNT_W'(3);
                pos_next  = '0;
                hold_next = '0;
            end
            else
            begin
                hold_next = {hold_reg[11:0], sx[5:0]};
                pos_next  = pos_reg + 2'd1;
            end
        end
        else
        begin
            stop_next = 1'b1;
            if (tc_reg != 2'd3)
                tc_next = tc_reg + 2'd1;
            if (item.char_in != CHAR_PAD)
                tnp_next = 1'b1;
        end

        bad = (tc_next == 2'd3) || tnp_next;

        if (item.end_of_string)
        begin
            if (!bad)
            begin
                if (pos_next == 2'd2)
                begin
                    slots[0] = make_data(hold_next[11:4]);
                    k        = COUNT_W'(1);
                end
                else if (pos_next == 2'd3)
                begin
                    slots[0] = make_data(hold_next[17:10]);
                    slots[1] = make_data(hold_next[9:2]);
                    k        = COUNT_W'(2);
                end
            end
            slots[k[1:0]] = make_status(bad);
            k             = k + COUNT_W'(1);
            // string done: clear for the next one
            pos_next  = '0;
            hold_next = '0;
            stop_next = 1'b0;
            tc_next   = '0;
            tnp_next  = 1'b0;
        end

        group.count = k;
        group.slots = slots;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            hold_reg <= '0;
            stop_reg <= 1'b0;
            tc_reg   <= '0;
            tnp_reg  <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg  <= pos_next;
            hold_reg <= hold_next;
            stop_reg <= stop_next;
            tc_reg   <= tc_next;
            tnp_reg  <= tnp_next;
        end
    end

endmodule

// ===== src/b64u_result_buf.sv =====
// Result buffer: holds the results of one character and hands them out
// one per cycle unless stalled, oldest first. Depends on b64u_pkg.
module b64u_result_buf (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  b64u_pkg::b64u_group_t       group,
    output logic                        result_valid,
    input  logic                        result_stall,
    output b64u_pkg::b64u_result_t      result_item,
    output b64u_pkg::b64u_buf_status_t  status
);
    import b64u_pkg::*;

    b64u_result_t       slot_reg [RESULTS_MAX];
    logic [COUNT_W-1:0] cnt_reg;
    logic               fire;

    assign result_valid = (cnt_reg != '0);
    assign result_item  = slot_reg[0];
    assign fire         = result_valid && !result_stall;
    assign status.free  = (cnt_reg == '0) || ((cnt_reg == COUNT_W'(1)) && fire);
    assign status.count = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (load)
            cnt_reg <= group.count;
        else if (fire)
            cnt_reg <= cnt_reg - COUNT_W'(1);
    end

    // payload: shift toward slot 0 as results leave
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < RESULTS_MAX; i++)
                slot_reg[i] <= group.slots[i];
        end
        else if (fire)
        begin
            for (int i = 0; i < RESULTS_MAX - 1; i++)
                slot_reg[i] <= slot_reg[i + 1];
        end
    end

endmodule

// ===== src/base64url_decoder.sv =====
// Top level of the base64url decoder: input register, decode step, result buffer.
// Depends on b64u_pkg, b64u_decode, b64u_result_buf and assert_macros.svh.
`include "assert_macros.svh"

// Streaming base64url decoder. One character enters per item on the char
// channel with end_of_string marking the last character of a string. Each
// complete group of four alphabet characters gives three data bytes; the
// end of a string gives the bytes of a well-formed partial group and then a
// status item (is_status=1, last_result=1, status_code=1 when malformed).
// Decoding stops at the first '=' or non-alphabet character; at most two
// trailing characters, all '=', are allowed. Data bytes already delivered
// for a malformed string stay delivered and should be dropped downstream.
// Rate: a character that gives no result is taken every cycle. A character
// that gives results (group end or string end) loads 1 to 4 results into
// the result buffer, which sends one result per cycle unless stalled. A
// result-giving character that finds the buffer still busy waits in the
// input register, stalling the input, until the last buffered result
// leaves. Unstalled, a long string streams at one character per cycle
// (three results per four characters); short strings, whose statuses add
// results, are held to the one-result-per-cycle output port. Data flows
// through the input register and then the result buffer.
module base64url_decoder (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     char_valid,
    output logic                     char_stall,
    input  b64u_pkg::b64u_in_t       char_item,
    output logic                     result_valid,
    input  logic                     result_stall,
    output b64u_pkg::b64u_result_t   result_item
);
    import b64u_pkg::*;

    b64u_in_t          char_reg;
    logic              char_valid_reg;
    b64u_group_t       group;
    b64u_buf_status_t  buf_status;
    logic              consume;
    logic              load;

    // An item with no results is retired at once; one with results needs
    // the buffer empty, or emptying this cycle.
    assign consume    = char_valid_reg && ((group.count == '0) || buf_status.free);
    assign load       = consume && (group.count != '0);
    assign char_stall = char_valid_reg && !consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            char_valid_reg <= 1'b0;
        else if (!char_stall)
            char_valid_reg <= char_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!char_stall && char_valid)
            char_reg <= char_item;
    end

    b64u_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (char_reg),
        .advance (consume),
        .group   (group)
    );

    b64u_result_buf u_result_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .group        (group),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .status       (buf_status)
    );

    // status item closes a string and carries no byte
    `ASSERT_CLK(a_status_last, result_valid && result_item.is_status |-> result_item.last_result && (result_item.byte_out == 8'h00), "status result malformed")
    // data items never carry status fields
    `ASSERT_CLK(a_data_clean, result_valid && !result_item.is_status |-> !result_item.status_code && !result_item.last_result, "data result carries status")
    // a group is never loaded over undelivered results
    `ASSERT_NEVER(a_no_overwrite, load && !buf_status.free, "result buffer overwritten")
    // buffered result count never exceeds RESULTS_MAX (one group)
    `ASSERT_NEVER(a_count_range, buf_status.count > COUNT_W'(RESULTS_MAX), "result count out of range")

endmodule
